@@ hdl/chunk_sum_checksum_framer_defines.svh @@
// Assertion helpers used by the framer back end (csf_back).
// Each macro expects signals named clk and rst in the using scope.
`ifndef CHUNK_SUM_CHECKSUM_FRAMER_DEFINES_SVH
`define CHUNK_SUM_CHECKSUM_FRAMER_DEFINES_SVH

// Same-cycle implication.
`define CSF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// Next-cycle implication.
`define CSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

@@ hdl/csf_pkg.sv @@
`timescale 1ns / 1ps
package csf_pkg;

  localparam logic [7:0]  BYTE_LF     = 8'h0A;
  localparam logic [7:0]  BYTE_CR     = 8'h0D;
  localparam int          SUM_BYTES   = 4;
  localparam int          LEN_W       = 17;
  localparam logic [16:0] LEN_RESET   = 17'd8192;
  localparam int          QUEUE_DEPTH = 2;

  // One classified item handed from front to back.
  typedef struct packed {
    logic [7:0]  data;
    logic        close;
    logic [31:0] sum;
  } csf_entry_t;

endpackage

@@ hdl/csf_front.sv @@
`timescale 1ns / 1ps
module csf_front #(
  parameter int MAX_CHUNK_LENGTH = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [16:0]         cfg_write_data,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  input  logic                last_byte,
  output csf_pkg::csf_entry_t entry
);
  import csf_pkg::*;

  localparam logic [20:0] MAX_LEN = 21'(MAX_CHUNK_LENGTH);

  logic [LEN_W-1:0] chunk_length;
  logic [LEN_W-1:0] bytes_in_chunk;
  logic [LEN_W-1:0] bytes_in_chunk_next;
  logic [31:0]      chunk_sum;
  logic [31:0]      chunk_sum_next;
  logic [20:0]      len_wide;
  logic [LEN_W-1:0] len_eff;
  logic [7:0]       data;
  logic             close;

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_length <= LEN_RESET;
    end else if (cfg_write_en) begin
      chunk_length <= cfg_write_data;
    end
  end

  // Effective length: zero acts as one, saturate at the maximum
  always_comb begin
    len_wide = (chunk_length == '0) ? 21'd1 : {4'd0, chunk_length};
    if (len_wide > MAX_LEN) begin
      len_wide = MAX_LEN;
    end
    len_eff = len_wide[LEN_W-1:0];
  end

  // Classify the item
  always_comb begin
    data                = (in_byte == BYTE_LF) ? BYTE_CR : in_byte;
    chunk_sum_next      = chunk_sum + {24'd0, data};
    bytes_in_chunk_next = bytes_in_chunk + 17'd1;
    close               = last_byte || (bytes_in_chunk_next >= len_eff);
    entry.data          = data;
    entry.close         = close;
    entry.sum           = chunk_sum_next;
  end

  // Chunk state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_chunk <= '0;
      chunk_sum      <= '0;
    end else if (in_fire) begin
      bytes_in_chunk <= close ? '0 : bytes_in_chunk_next;
      chunk_sum      <= close ? '0 : chunk_sum_next;
    end
  end

endmodule

@@ hdl/csf_queue.sv @@
`timescale 1ns / 1ps
module csf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  csf_pkg::csf_entry_t push_entry,
  input  logic                pop,
  output logic                q_valid,
  output logic                q_full,
  output csf_pkg::csf_entry_t q_entry
);
  import csf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  csf_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_valid = (fill != '0);
  assign q_full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign q_entry = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ hdl/csf_back.sv @@
`timescale 1ns / 1ps
`include "chunk_sum_checksum_framer_defines.svh"
module csf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  csf_pkg::csf_entry_t q_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                is_checksum,
  output logic                chunk_end,
  output logic                run_last
);
  import csf_pkg::*;

  localparam int LEFT_W = $clog2(SUM_BYTES + 1);

  logic              out_fire;
  logic [LEFT_W-1:0] chk_left;
  logic [31:0]       sum_hold;

  assign out_fire = out_valid && !out_stall;
  // Take a new entry once the current item has no checksum bytes pending
  assign pop = q_valid && (!out_valid || (out_fire && chk_left == '0));

  // Output control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      chk_left  <= '0;
    end else if (pop) begin
      out_valid <= 1'b1;
      chk_left  <= q_entry.close ? LEFT_W'(SUM_BYTES) : '0;
    end else if (out_fire) begin
      if (chk_left != '0) begin
        chk_left <= chk_left - 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload: data byte, then for a closing item the sum bytes most significant first
  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte    <= q_entry.data;
      is_checksum <= 1'b0;
      chunk_end   <= 1'b0;
      run_last    <= !q_entry.close;
      sum_hold    <= q_entry.sum;
    end else if (out_fire && chk_left != '0) begin
      out_byte    <= sum_hold[31:24];
      is_checksum <= 1'b1;
      chunk_end   <= (chk_left == LEFT_W'(1));
      run_last    <= (chk_left == LEFT_W'(1));
      sum_hold    <= {sum_hold[23:0], 8'd0};
    end
  end

  `CSF_ASSERT_NOW(a_left_range, 1'b1, chk_left <= LEFT_W'(SUM_BYTES))
  `CSF_ASSERT_NOW(a_end_is_last, out_valid && chunk_end, is_checksum && run_last)
  `CSF_ASSERT_NEXT(a_sum_follows, out_fire && chk_left != '0, out_valid && is_checksum)
  `CSF_ASSERT_NOW(a_no_pop_pending, pop && out_valid, chk_left == '0)

endmodule

@@ hdl/chunk_sum_checksum_framer.sv @@
`timescale 1ns / 1ps
// An accepted item is classified and written into the queue, then loaded into the
// output register; sum bytes of a closing item follow, one per cycle unless stalled.
// Throughput: one item per cycle unless stalled; a closing item holds the output
// while the single output register emits its data byte and sum bytes, one byte each cycle.
// Reset (rst, synchronous, active high): empties the queue and output, clears
// count and sum, and sets the chunk length to 8192.
module chunk_sum_checksum_framer #(
  parameter int MAX_CHUNK_LENGTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [16:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_checksum,
  output logic        chunk_end,
  output logic        run_last
);
  import csf_pkg::*;

  logic       in_fire;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  csf_entry_t push_entry;
  csf_entry_t q_entry;

  assign in_stall = q_full;
  assign in_fire  = in_valid && !q_full;

  csf_front #(.MAX_CHUNK_LENGTH(MAX_CHUNK_LENGTH)) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_fire        (in_fire),
    .in_byte        (in_byte),
    .last_byte      (last_byte),
    .entry          (push_entry)
  );

  csf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_fire),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .q_entry    (q_entry)
  );

  csf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .is_checksum (is_checksum),
    .chunk_end   (chunk_end),
    .run_last    (run_last)
  );

endmodule
